FILE: hw/rtl/touch_press_history_classifier_macros.svh
// ----------------------------------------------------------------------------
// Touch press history classifier assertion macros
// Immediate-implication and next-cycle-implication assertions on i_clk,
// disabled while i_rst_n is low. The bodies are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PRESS_HISTORY_CLASSIFIER_MACROS_SVH
`define TOUCH_PRESS_HISTORY_CLASSIFIER_MACROS_SVH

`ifndef SYNTH
`define TPHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TPHC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPHC_ASSERT_IMP(lbl, ante, cons, msg)
`define TPHC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/tphc_pkg.sv
// ----------------------------------------------------------------------------
// Touch press history classifier package
// Field widths, status and register index codes, and the scan word that
// ripples along the history cells.
// ----------------------------------------------------------------------------
package tphc_pkg;

    localparam int SPAN_W    = 6;
    localparam int AGE_W     = 5;
    localparam int STATUS_W  = 3;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 2;

    localparam int AGE_MAX = (1 << AGE_W) - 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_TOUCHED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_REPEAT   = 3'd3,
        ST_HELD     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_FRAMES  = 2'd0,
        CFG_DBL_TAP_WINDOW = 2'd1
    } t_cfg_idx;

    localparam logic [SPAN_W-1:0] REPEAT_FRAMES_RST  = 6'd20;
    localparam logic [SPAN_W-1:0] DBL_TAP_WINDOW_RST = 6'd15;

    typedef struct packed {
        logic             all_set;
        logic             found;
        logic             any_set;
        logic [AGE_W-1:0] age;
    } t_scan;

endpackage

FILE: hw/rtl/touch_press_history_classifier.sv
// A result is registered on the output register in the cycle after its beat.
// Throughput: one beat per cycle while o_stall is low; the history cells
// shift once per beat and the scan word ripples through all LOG_DEPTH-1 cells
// within that cycle. Reset clears the press history and the output valid bit,
// and restores the span registers to 20 and 15. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Touch press history classifier
// Classifies each touch frame from its pressed flag and a shifting row of
// history cells, and flags press age and double taps.
// ----------------------------------------------------------------------------
`include "touch_press_history_classifier_macros.svh"

module touch_press_history_classifier #(
    parameter int LOG_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tphc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tphc_pkg::SPAN_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_pressed,
    input  logic [tphc_pkg::COORD_W-1:0]    i_pos_x,
    input  logic [tphc_pkg::COORD_W-1:0]    i_pos_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tphc_pkg::STATUS_W-1:0]   o_status,
    output logic [tphc_pkg::AGE_W-1:0]      o_press_age,
    output logic                            o_dbl_tap,
    output logic [tphc_pkg::COORD_W-1:0]    o_out_x,
    output logic [tphc_pkg::COORD_W-1:0]    o_out_y
);
    import tphc_pkg::*;

    localparam int NCELL = LOG_DEPTH - 1;

    logic [SPAN_W-1:0]  r_repeat_frames;
    logic [SPAN_W-1:0]  r_dbl_tap_window;
    logic               r_valid;
    t_status            r_status;
    logic [AGE_W-1:0]   r_press_age;
    logic               r_dbl_tap;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;

    logic               n_valid;
    logic               in_acc;
    logic [NCELL-1:0]   w_flag;
    logic [NCELL-1:0]   w_shin;
    t_scan              w_scan [0:NCELL];
    t_scan              scan_fin;
    t_status            status;
    logic [AGE_W-1:0]   press_age;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_frames  <= REPEAT_FRAMES_RST;
            r_dbl_tap_window <= DBL_TAP_WINDOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REPEAT_FRAMES: begin
                    r_repeat_frames <= i_cfg_data;
                end
                CFG_DBL_TAP_WINDOW: begin
                    r_dbl_tap_window <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall = r_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    assign w_shin    = {w_flag[NCELL-2:0], i_pressed};
    assign w_scan[0] = '{all_set: 1'b1, found: 1'b0, any_set: 1'b0, age: '0};

    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        tphc_cell #(
            .POS (gi + 1)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_shift          (in_acc),
            .i_flag_in        (w_shin[gi]),
            .i_repeat_frames  (r_repeat_frames),
            .i_dbl_tap_window (r_dbl_tap_window),
            .i_scan           (w_scan[gi]),
            .o_scan           (w_scan[gi+1]),
            .o_flag           (w_flag[gi])
        );
    end

    assign scan_fin = w_scan[NCELL];

    always_comb begin
        case ({i_pressed, w_flag[0]})
            2'b10: begin
                status = ST_TOUCHED;
            end
            2'b01: begin
                status = ST_RELEASED;
            end
            2'b11: begin
                status = scan_fin.all_set ? ST_REPEAT : ST_HELD;
            end
            default: begin
                status = ST_NONE;
            end
        endcase
    end

    assign press_age = (status != ST_NONE) ? scan_fin.age : '0;

    assign n_valid = in_acc || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status    <= status;
            r_press_age <= press_age;
            r_dbl_tap   <= scan_fin.any_set;
            r_out_x     <= i_pos_x;
            r_out_y     <= i_pos_y;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_press_age = r_press_age;
    assign o_dbl_tap   = r_dbl_tap;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

    `TPHC_ASSERT_NXT(a_hist_shift, in_acc, w_flag[0] == $past(i_pressed), "history stuck")
    `TPHC_ASSERT_NXT(a_beat_out, in_acc, r_valid, "accepted beat produced no result")
    `TPHC_ASSERT_IMP(a_none_age, r_valid && (r_status == ST_NONE), r_press_age == '0, "stray age")
    `TPHC_ASSERT_IMP(a_empty_take, !r_valid, !o_stall, "stall while output empty")

endmodule

FILE: hw/rtl/tphc_cell.sv
// ----------------------------------------------------------------------------
// Touch press history cell
// Holds the pressed flag from POS frames ago, hands it to the next cell on
// every accepted beat and at POS >= 2 adds its flag to the rippling scan word.
// ----------------------------------------------------------------------------
module tphc_cell #(
    parameter int POS = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic                         i_flag_in,
    input  logic [tphc_pkg::SPAN_W-1:0]  i_repeat_frames,
    input  logic [tphc_pkg::SPAN_W-1:0]  i_dbl_tap_window,
    input  tphc_pkg::t_scan              i_scan,
    output tphc_pkg::t_scan              o_scan,
    output logic                         o_flag
);
    import tphc_pkg::*;

    localparam bit               IN_SCAN = (POS >= 2);
    localparam logic [SPAN_W-1:0] POS_V  = SPAN_W'(POS);
    localparam int               AGE_I   = ((POS - 1) > AGE_MAX) ? AGE_MAX : (POS - 1);
    localparam logic [AGE_W-1:0] AGE_V   = AGE_W'(AGE_I);

    logic r_flag;
    logic in_rep;
    logic in_dtap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_shift) begin
            r_flag <= i_flag_in;
        end
    end

    assign in_rep  = IN_SCAN && (POS_V < i_repeat_frames);
    assign in_dtap = IN_SCAN && (POS_V < i_dbl_tap_window);

    always_comb begin
        o_scan = i_scan;
        if (in_rep && !r_flag) begin
            o_scan.all_set = 1'b0;
        end
        if (IN_SCAN && !i_scan.found && !r_flag) begin
            o_scan.found = 1'b1;
            o_scan.age   = AGE_V;
        end
        if (in_dtap && r_flag) begin
            o_scan.any_set = 1'b1;
        end
    end

    assign o_flag = r_flag;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch press history classifier testbench
// Sends frame samples through the valid/stall channel and keeps its own
// shadow of the press history and span registers to predict each frame's
// class, press age, double tap flag and coordinates. Directed tests come
// first, then backpressure, then random press and release runs under many
// span settings. Both sides of the channel idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import tphc_pkg::*;

    localparam int DEPTH      = 32;
    localparam int TIMEOUT_NS = 1_000_000;

    typedef struct packed {
        t_status            status;
        logic [AGE_W-1:0]   age;
        logic               dtap;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_frame_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SPAN_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_pressed;
    logic [COORD_W-1:0]   i_pos_x;
    logic [COORD_W-1:0]   i_pos_y;
    logic                 o_valid;
    logic                 i_stall;
    logic [STATUS_W-1:0]  o_status;
    logic [AGE_W-1:0]     o_press_age;
    logic                 o_dbl_tap;
    logic [COORD_W-1:0]   o_out_x;
    logic [COORD_W-1:0]   o_out_y;

    t_frame_result     frame_exp_q[$];
    logic [DEPTH-2:0]  press_hist;
    logic [SPAN_W-1:0] repeat_span;
    logic [SPAN_W-1:0] tap_span;
    int                error_count     = 0;
    int                frames_sent     = 0;
    int                results_checked = 0;
    int                span_writes     = 0;
    int                status_seen [5] = '{0, 0, 0, 0, 0};
    bit                idle_on         = 1'b1;
    bit                hold_req        = 1'b0;
    int                hold_len        = 0;

    touch_press_history_classifier #(
        .LOG_DEPTH(DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pressed   (i_pressed),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_press_age (o_press_age),
        .o_dbl_tap   (o_dbl_tap),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_frame_result classify_frame(input logic pressed,
                                                     input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        logic [DEPTH-1:0] h;
        int               rf;
        int               tw;
        bit               all_held;
        bit               found;
        t_frame_result    r;
        h  = {press_hist, pressed};
        rf = (repeat_span > DEPTH) ? DEPTH : int'(repeat_span);
        tw = (tap_span > DEPTH) ? DEPTH : int'(tap_span);
        r.age  = '0;
        r.dtap = 1'b0;
        r.x    = x;
        r.y    = y;
        if (pressed && !h[1]) begin
            r.status = ST_TOUCHED;
        end else if (!pressed && h[1]) begin
            r.status = ST_RELEASED;
        end else if (pressed && h[1]) begin
            all_held = 1'b1;
            for (int i = 2; i < rf; i++) begin
                if (!h[i]) all_held = 1'b0;
            end
            r.status = all_held ? ST_REPEAT : ST_HELD;
        end else begin
            r.status = ST_NONE;
        end
        found = 1'b0;
        if (r.status != ST_NONE) begin
            for (int i = 2; i < DEPTH; i++) begin
                if (!found && !h[i]) begin
                    r.age = AGE_W'(i - 1);
                    found = 1'b1;
                end
            end
        end
        for (int i = 2; i < tw; i++) begin
            if (h[i]) r.dtap = 1'b1;
        end
        press_hist = h[DEPTH-2:0];
        return r;
    endfunction

    task automatic send_frame(input logic pressed, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y);
        t_frame_result r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pressed <= pressed;
        i_pos_x   <= x;
        i_pos_y   <= y;
        do @(posedge i_clk); while (o_stall);
        r = classify_frame(pressed, x, y);
        frame_exp_q = {frame_exp_q, r};
        status_seen[r.status]++;
        frames_sent++;
    endtask

    task automatic send_random_frame(input logic pressed);
        send_frame(pressed, COORD_W'($urandom_range(0, 4095)),
                   COORD_W'($urandom_range(0, 4095)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (frame_exp_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_span(input t_cfg_idx idx, input logic [SPAN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_REPEAT_FRAMES) begin
            repeat_span = value;
        end else begin
            tap_span = value;
        end
        span_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_spans(input logic [SPAN_W-1:0] rf, input logic [SPAN_W-1:0] tw);
        drain();
        write_span(CFG_REPEAT_FRAMES, rf);
        write_span(CFG_DBL_TAP_WINDOW, tw);
    endtask

    function automatic logic [SPAN_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd2;
            3: return 6'd3;
            4: return 6'd31;
            5: return 6'd32;
            6: return 6'd33;
            7: return 6'd63;
            default: return SPAN_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] corner_coord(input int k);
        case (k % 4)
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'hAAA;
            default: return 12'h555;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_exp_q.size() == 0) begin
                error_count++;
                $display("%0t: result beat with no frame waiting, status %0d", $time,
                         o_status);
            end else begin
                exp_r = frame_exp_q.pop_front();
                results_checked++;
                check_field("status", 16'(exp_r.status), 16'(o_status));
                check_field("press_age", 16'(exp_r.age), 16'(o_press_age));
                check_field("dbl_tap", 16'(exp_r.dtap), 16'(o_dbl_tap));
                check_field("out_x", 16'(exp_r.x), 16'(o_out_x));
                check_field("out_y", 16'(exp_r.y), 16'(o_out_y));
            end
        end
    end

    initial begin : receiver
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13) - 1) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic test_reset_defaults();
        send_frame(1'b0, 12'h000, 12'h000);
        for (int i = 0; i < 22; i++) begin
            send_frame(1'b1, corner_coord(i), corner_coord(i + 1));
        end
        send_frame(1'b0, 12'hFFF, 12'hFFF);
        send_frame(1'b1, 12'h555, 12'hAAA);
    endtask

    task automatic test_directed_classes();
        bit pattern [16] = '{0, 1, 0, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 1, 1, 0};
        set_spans(6'd4, 6'd5);
        for (int i = 0; i < 16; i++) begin
            send_frame(pattern[i], corner_coord(i), corner_coord(i + 1));
        end
    endtask

    task automatic test_span_extremes();
        logic [SPAN_W-1:0] rf_set [5] = '{6'd0, 6'd1, 6'd63, 6'd32, 6'd33};
        logic [SPAN_W-1:0] tw_set [5] = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd2};
        for (int k = 0; k < 5; k++) begin
            set_spans(rf_set[k], tw_set[k]);
            for (int i = 0; i < 34; i++) send_random_frame(1'b1);
            send_random_frame(1'b0);
            send_random_frame(1'b0);
            send_random_frame(1'b1);
            send_random_frame(1'b0);
        end
    endtask

    task automatic test_backpressure();
        set_spans(6'd20, 6'd15);
        idle_on  = 1'b0;
        hold_len = 100;
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_random_frame((i % 7) != 0);
        end
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int n;
        int run;
        for (int p = 0; p < 6; p++) begin
            set_spans(pick_span(), pick_span());
            idle_on = (p != 2) && (p != 5);
            n = 0;
            while (n < 200) begin
                if ($urandom_range(0, 9) < 8) begin
                    run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
                    for (int i = 0; i < run; i++) send_random_frame(1'b1);
                    n += run;
                    run = $urandom_range(1, 6);
                    for (int i = 0; i < run; i++) send_random_frame(1'b0);
                    n += run;
                end else begin
                    for (int i = 0; i < 10; i++) begin
                        send_random_frame(logic'($urandom_range(0, 1)));
                    end
                    n += 10;
                end
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_REPEAT_FRAMES;
        i_cfg_data  <= '0;
        i_pressed   <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        press_hist  = '0;
        repeat_span = REPEAT_FRAMES_RST;
        tap_span    = DBL_TAP_WINDOW_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_classes();
        test_span_extremes();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d frames and compared %0d results over %0d span register writes.",
                 frames_sent, results_checked, span_writes);
        $display("Classes: none %0d, touched %0d, released %0d, repeating %0d, held %0d.",
                 status_seen[ST_NONE], status_seen[ST_TOUCHED], status_seen[ST_RELEASED],
                 status_seen[ST_REPEAT], status_seen[ST_HELD]);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
